@@ rtl/assert_macros.svh @@
// Assertion macros for the RTL of the AES-128 block, included by aes_ctrl.
// No dependencies; SYNTH removes every check.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPL(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error("never failed");
`else
`define ASSERT_IMPL(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, expr)
`endif
`endif

@@ rtl/aes_pkg.sv @@
// Package for the AES-128 block: types, states, S-box tables and GF(2^8) helpers.
// No dependencies.
package aes_pkg;
  localparam int unsigned NumRounds = 10;
  localparam int unsigned NumWords = 44;
  localparam int unsigned WordAw = 6;
  localparam int unsigned RndW = 4;
  localparam logic CfgKeyHigh = 1'b0;
  localparam logic CfgKeyLow = 1'b1;

  typedef struct packed {
    logic        func;
    logic [63:0] block_high;
    logic [63:0] block_low;
  } in_t;

  typedef struct packed {
    logic [63:0] result_high;
    logic [63:0] result_low;
  } out_t;

  typedef enum logic [2:0] {
    StIdle, StExpand, StLoad, StRound, StDone
  } state_e;

  typedef struct packed {
    logic          exp_start;
    logic          exp_step;
    logic [5:0]    exp_idx;
    logic          load;
    logic          rnd_step;
    logic [RndW-1:0] rnd;
    logic [WordAw-1:0] rk_addr;
    logic          done;
  } ctrl_t;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
    return t[a];
  endfunction

  function automatic logic [7:0] inv_sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
    return t[a];
  endfunction

  function automatic logic [7:0] xt(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] rcon(input logic [3:0] r);
    logic [7:0] v;
    case (r)
      4'd1: v = 8'h01;
      4'd2: v = 8'h02;
      4'd3: v = 8'h04;
      4'd4: v = 8'h08;
      4'd5: v = 8'h10;
      4'd6: v = 8'h20;
      4'd7: v = 8'h40;
      4'd8: v = 8'h80;
      4'd9: v = 8'h1b;
      4'd10: v = 8'h36;
      default: v = 8'h00;
    endcase
    return v;
  endfunction
endpackage

@@ rtl/aes_ram.sv @@
// Generic single-port-write, registered-read RAM.
// No dependencies.
module aes_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 44
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

@@ rtl/aes_ctrl.sv @@
// Controller FSM for the AES-128 block: key expansion sequencing and round count.
// Depends on aes_pkg and assert_macros.svh.
`include "assert_macros.svh"
module aes_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           key_we_i,
  input  logic           start_i,
  input  logic           func_i,
  output logic           busy_o,
  output aes_pkg::ctrl_t ctrl_o
);
  aes_pkg::state_e state_q, state_d;
  logic [5:0] cnt_q, cnt_d;
  logic enc_q, enc_d;
  logic pend_q, pend_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      aes_pkg::StIdle: begin
        if (pend_q) state_d = aes_pkg::StExpand;
        else if (start_i) state_d = aes_pkg::StLoad;
      end
      aes_pkg::StExpand: begin
        if (key_we_i) state_d = aes_pkg::StExpand;
        else if (cnt_q == 6'(aes_pkg::NumWords - 1)) state_d = aes_pkg::StIdle;
      end
      aes_pkg::StLoad: state_d = aes_pkg::StRound;
      aes_pkg::StRound: begin
        if (cnt_q == 6'(aes_pkg::NumRounds)) state_d = aes_pkg::StDone;
      end
      aes_pkg::StDone: state_d = aes_pkg::StIdle;
      default: state_d = aes_pkg::StIdle;
    endcase
  end

  always_comb begin
    cnt_d = cnt_q;
    enc_d = enc_q;
    pend_d = pend_q | key_we_i;
    case (state_q)
      aes_pkg::StIdle: begin
        if (pend_q) begin
          cnt_d = 6'd4;
          pend_d = key_we_i;
        end else if (start_i) begin
          cnt_d = 6'd0;
          enc_d = func_i;
        end
      end
      aes_pkg::StExpand: begin
        if (key_we_i) cnt_d = 6'd4;
        else cnt_d = cnt_q + 6'd1;
        pend_d = 1'b0;
      end
      aes_pkg::StLoad, aes_pkg::StRound: cnt_d = cnt_q + 6'd1;
      default: ;
    endcase
  end

  // round key needed next cycle; the RAM read is registered
  logic [3:0] kr;
  always_comb begin
    ctrl_o = '0;
    kr = enc_d ? 4'(cnt_d) : 4'(6'(aes_pkg::NumRounds) - cnt_d);
    ctrl_o.rnd = 4'(cnt_q);
    ctrl_o.exp_idx = cnt_q;
    case (state_q)
      aes_pkg::StIdle: begin
        ctrl_o.exp_start = pend_q;
        ctrl_o.rk_addr = 6'd0;
      end
      aes_pkg::StExpand: begin
        ctrl_o.exp_step = ~key_we_i;
        ctrl_o.exp_start = key_we_i;
      end
      aes_pkg::StLoad: ctrl_o.load = 1'b1;
      aes_pkg::StRound: ctrl_o.rnd_step = 1'b1;
      aes_pkg::StDone: ctrl_o.done = 1'b1;
      default: ;
    endcase
    ctrl_o.rk_addr = {kr, 2'b00};
  end

  assign busy_o = (state_q != aes_pkg::StIdle) | pend_q | key_we_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= aes_pkg::StIdle;
      cnt_q <= '0;
      enc_q <= 1'b0;
      pend_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
      enc_q <= enc_d;
      pend_q <= pend_d;
    end
  end

  `ASSERT_IMPL(a_done_after_round, clk_i, rst_ni, ctrl_o.done |-> $past(state_q == aes_pkg::StRound))
  `ASSERT_NEVER(a_round_range, clk_i, rst_ni, state_q == aes_pkg::StRound && cnt_q > 6'(aes_pkg::NumRounds))
  `ASSERT_IMPL(a_busy_when_work, clk_i, rst_ni, (state_q == aes_pkg::StRound) |-> busy_o)
endmodule

@@ rtl/aes_datapath.sv @@
// Datapath for the AES-128 block: round-key store and expansion, state register and round logic.
// Depends on aes_pkg and aes_ram.
module aes_datapath (
  input  logic           clk_i,
  input  logic [127:0]   key_i,
  input  logic           enc_i,
  input  aes_pkg::in_t   in_i,
  input  logic           start_i,
  input  aes_pkg::ctrl_t ctrl_i,
  output aes_pkg::out_t  out_o
);
  // Round keys kept as four 32-bit word RAMs, one per column; read a full key each cycle.
  logic [127:0] st_q, st_d;
  logic [127:0] in_q;
  logic enc_q;
  logic [31:0] w_q [4];
  logic [31:0] w_d [4];
  logic we;
  logic [3:0] wr_rnd;
  logic [31:0] rd [4];
  logic [3:0] rd_rnd;

  // next round key (4 words) from the previous one; stored on expand steps whose index is a multiple of four
  always_comb begin
    logic [31:0] t;
    t = {w_q[3][23:0], w_q[3][31:24]};
    t = {aes_pkg::sbox(t[31:24]), aes_pkg::sbox(t[23:16]),
         aes_pkg::sbox(t[15:8]), aes_pkg::sbox(t[7:0])};
    t = t ^ {aes_pkg::rcon(wr_rnd), 24'h0};
    w_d[0] = w_q[0] ^ t;
    w_d[1] = w_q[1] ^ w_d[0];
    w_d[2] = w_q[2] ^ w_d[1];
    w_d[3] = w_q[3] ^ w_d[2];
    if (ctrl_i.exp_start) begin
      w_d[0] = key_i[127:96];
      w_d[1] = key_i[95:64];
      w_d[2] = key_i[63:32];
      w_d[3] = key_i[31:0];
    end
  end

  logic [3:0] exp_rnd_q;
  assign we = ctrl_i.exp_start | (ctrl_i.exp_step && ctrl_i.exp_idx[1:0] == 2'd0 &&
                                  ctrl_i.exp_idx <= 6'd40);
  assign wr_rnd = ctrl_i.exp_start ? 4'd0 : exp_rnd_q + 4'd1;
  always_ff @(posedge clk_i) begin
    if (we) begin
      for (int i = 0; i < 4; i++) w_q[i] <= w_d[i];
      exp_rnd_q <= wr_rnd;
    end
  end

  // rk read address for next cycle
  assign rd_rnd = ctrl_i.rk_addr[5:2];
  for (genvar c = 0; c < 4; c++) begin : g_col
    aes_ram #(.Width(32), .Depth(16)) u_ram (
      .clk_i  (clk_i),
      .we_i   (we),
      .waddr_i(wr_rnd),
      .wdata_i(w_d[c]),
      .raddr_i(rd_rnd),
      .rdata_o(rd[c])
    );
  end
  logic [127:0] rk;
  assign rk = {rd[0], rd[1], rd[2], rd[3]};

  // round function
  logic [127:0] sb, sr, mc, a, r;
  logic last;
  assign last = enc_q ? (ctrl_i.rnd == 4'(aes_pkg::NumRounds))
                      : (ctrl_i.rnd == 4'(aes_pkg::NumRounds));
  always_comb begin
    logic [7:0] b [16];
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3, u, v;
    u = '0;
    v = '0;
    for (int i = 0; i < 16; i++) b[i] = st_q[127 - 8*i -: 8];
    if (enc_q) begin
      for (int i = 0; i < 16; i++) b[i] = aes_pkg::sbox(b[i]);
      for (int c = 0; c < 4; c++)
        for (int rr = 0; rr < 4; rr++) t[4*c+rr] = b[rr + 4*((c+rr)%4)];
      for (int c = 0; c < 4; c++) begin
        a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
        if (!last) begin
          t[4*c]   = aes_pkg::xt(a0) ^ aes_pkg::xt(a1) ^ a1 ^ a2 ^ a3;
          t[4*c+1] = a0 ^ aes_pkg::xt(a1) ^ aes_pkg::xt(a2) ^ a2 ^ a3;
          t[4*c+2] = a0 ^ a1 ^ aes_pkg::xt(a2) ^ aes_pkg::xt(a3) ^ a3;
          t[4*c+3] = aes_pkg::xt(a0) ^ a0 ^ a1 ^ a2 ^ aes_pkg::xt(a3);
        end
      end
      for (int i = 0; i < 16; i++) t[i] = t[i] ^ rk[127 - 8*i -: 8];
    end else begin
      // inverse: InvShiftRows, InvSubBytes, AddRoundKey, InvMixColumns
      for (int c = 0; c < 4; c++)
        for (int rr = 0; rr < 4; rr++) t[4*c+rr] = b[rr + 4*((c+4-rr)%4)];
      for (int i = 0; i < 16; i++)
        t[i] = aes_pkg::inv_sbox(t[i]) ^ rk[127 - 8*i -: 8];
      for (int c = 0; c < 4; c++) begin
        a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
        u = aes_pkg::xt(aes_pkg::xt(a0 ^ a2));
        v = aes_pkg::xt(aes_pkg::xt(a1 ^ a3));
        a0 = a0 ^ u; a1 = a1 ^ v; a2 = a2 ^ u; a3 = a3 ^ v;
        if (!last) begin
          t[4*c]   = aes_pkg::xt(a0) ^ aes_pkg::xt(a1) ^ a1 ^ a2 ^ a3;
          t[4*c+1] = a0 ^ aes_pkg::xt(a1) ^ aes_pkg::xt(a2) ^ a2 ^ a3;
          t[4*c+2] = a0 ^ a1 ^ aes_pkg::xt(a2) ^ aes_pkg::xt(a3) ^ a3;
          t[4*c+3] = aes_pkg::xt(a0) ^ a0 ^ a1 ^ a2 ^ aes_pkg::xt(a3);
        end
      end
    end
    for (int i = 0; i < 16; i++) r[127 - 8*i -: 8] = t[i];
  end
  assign sb = '0;
  assign sr = sb;
  assign mc = sr;
  assign a  = in_q ^ rk;

  always_comb begin
    st_d = st_q;
    if (ctrl_i.load) st_d = a;
    else if (ctrl_i.rnd_step) st_d = r;
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      in_q  <= {in_i.block_high, in_i.block_low};
      enc_q <= enc_i;
    end
    st_q <= st_d | mc;
  end

  assign out_o.result_high = st_q[127:64];
  assign out_o.result_low  = st_q[63:0];
endmodule

@@ rtl/aes128_block_cipher.sv @@
// Top level of the AES-128 encrypt/decrypt block: ports, key registers, FSM and datapath.
// Depends on aes_pkg, aes_ctrl, aes_datapath.
//
// channel   direction  handshake                 payload
// config    in         cfg_we_i                  cfg_idx_i, cfg_data_i
// command   in         start_i & !busy_o         in_i
// result    out        done_o (one cycle)        out_o
//
// A block is loaded with the initial key addition, then runs ten rounds through the
// single round unit; done_o is high in the StDone state after the last round and busy_o
// drops once the FSM is back in idle. A new block is accepted only while busy_o is low.
// A key write holds busy_o high while the expansion computes and stores the round keys.
// The result stays on out_o until the next block loads.
// Reset clears the FSM and key registers, not the key RAM; results cannot be stalled.
module aes128_block_cipher (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic          cfg_idx_i,
  input  logic [63:0]   cfg_data_i,
  input  logic          start_i,
  input  aes_pkg::in_t  in_i,
  output logic          busy_o,
  output logic          done_o,
  output aes_pkg::out_t out_o
);
  logic [63:0] key_hi_q, key_lo_q;
  aes_pkg::ctrl_t ctrl;
  logic acc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_hi_q <= '0;
      key_lo_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == aes_pkg::CfgKeyHigh) key_hi_q <= cfg_data_i;
      else key_lo_q <= cfg_data_i;
    end
  end

  logic we_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) we_q <= 1'b0;
    else we_q <= cfg_we_i;
  end

  assign acc = start_i & ~busy_o;

  aes_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .key_we_i(we_q),
    .start_i (acc),
    .func_i  (in_i.func),
    .busy_o  (busy_o),
    .ctrl_o  (ctrl)
  );

  aes_datapath u_dp (
    .clk_i  (clk_i),
    .key_i  ({key_hi_q, key_lo_q}),
    .enc_i  (in_i.func),
    .in_i   (in_i),
    .start_i(acc),
    .ctrl_i (ctrl),
    .out_o  (out_o)
  );

  assign done_o = ctrl.done;
endmodule

@@ bench/aes128_block_cipher_test.sv @@
// Self-checking testbench for aes128_block_cipher: key writes, FIPS-197 vectors, random blocks.
// Predicts AES-128 encrypt/decrypt with its own round-key expansion; depends on aes_pkg.
`timescale 1ns / 1ps
module aes128_block_cipher_test;
  typedef enum logic [1:0] {OpBlock, OpKeyHigh, OpKeyLow, OpDrain} op_e;
  typedef struct {
    op_e          op;
    logic         func;
    logic [127:0] data;
  } job_t;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          cfg_we_i = 1'b0;
  logic          cfg_idx_i = aes_pkg::CfgKeyHigh;
  logic [63:0]   cfg_data_i = '0;
  logic          start_i = 1'b0;
  aes_pkg::in_t  in_i = '0;
  logic          busy_o, done_o;
  aes_pkg::out_t out_o;

  aes128_block_cipher u_dut (.*);

  always #2 clk_i = ~clk_i;

  job_t         pending_jobs[$];
  logic [127:0] cipher_expect[$];
  logic [7:0]   sbox_fwd[256];
  logic [7:0]   sbox_inv[256];
  logic [31:0]  key_sched[44];
  logic [63:0]  key_hi_q = '0, key_lo_q = '0;
  int           n_issued = 0, n_accepted = 0, n_results = 0, n_keys = 0, n_errors = 0;
  int           quiet_cycles = 0;

  function automatic logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
    logic [7:0] p;
    p = '0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p ^= a;
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    end
    return p;
  endfunction

  function automatic logic [7:0] rotl8(logic [7:0] v, int n);
    return (v << n) | (v >> (8 - n));
  endfunction

  initial begin
    logic [7:0] inv, s;
    for (int x = 0; x < 256; x++) begin
      inv = 8'h01;
      if (x == 0) inv = 8'h00;
      else repeat (254) inv = gf_mul(inv, x[7:0]);
      s = inv ^ rotl8(inv, 1) ^ rotl8(inv, 2) ^ rotl8(inv, 3) ^ rotl8(inv, 4) ^ 8'h63;
      sbox_fwd[x] = s;
      sbox_inv[s] = x[7:0];
    end
  end

  task automatic expand_keys();
    logic [31:0] t;
    logic [7:0]  rc;
    key_sched[0] = key_hi_q[63:32];
    key_sched[1] = key_hi_q[31:0];
    key_sched[2] = key_lo_q[63:32];
    key_sched[3] = key_lo_q[31:0];
    rc = 8'h01;
    for (int i = 4; i < 44; i++) begin
      t = key_sched[i-1];
      if (i % 4 == 0) begin
        t = {t[23:0], t[31:24]};
        t = {sbox_fwd[t[31:24]], sbox_fwd[t[23:16]], sbox_fwd[t[15:8]], sbox_fwd[t[7:0]]};
        t ^= {rc, 24'h0};
        rc = gf_mul(rc, 8'h02);
      end
      key_sched[i] = key_sched[i-4] ^ t;
    end
  endtask

  function automatic logic [127:0] aes_predict(logic enc, logic [127:0] blk);
    logic [7:0] st[16];
    logic [7:0] tmp[16];
    logic [7:0] a0, a1, a2, a3;
    logic [127:0] res;
    int rnd;
    for (int i = 0; i < 16; i++) st[i] = blk[127-8*i -: 8];
    for (int step = 0; step <= 10; step++) begin
      rnd = enc ? step : 10 - step;
      if (step != 0) begin
        for (int c = 0; c < 4; c++)
          for (int r = 0; r < 4; r++)
            tmp[4*c+r] = enc ? sbox_fwd[st[r + 4*((c + r) % 4)]]
                             : sbox_inv[st[r + 4*((c + 4 - r) % 4)]];
        st = tmp;
        if (enc && step != 10) begin
          for (int c = 0; c < 4; c++) begin
            a0 = st[4*c]; a1 = st[4*c+1]; a2 = st[4*c+2]; a3 = st[4*c+3];
            st[4*c]   = gf_mul(a0, 2) ^ gf_mul(a1, 3) ^ a2 ^ a3;
            st[4*c+1] = a0 ^ gf_mul(a1, 2) ^ gf_mul(a2, 3) ^ a3;
            st[4*c+2] = a0 ^ a1 ^ gf_mul(a2, 2) ^ gf_mul(a3, 3);
            st[4*c+3] = gf_mul(a0, 3) ^ a1 ^ a2 ^ gf_mul(a3, 2);
          end
        end
      end
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++)
          st[4*c+r] ^= key_sched[4*rnd+c][31-8*r -: 8];
      if (!enc && step != 0 && step != 10) begin
        for (int c = 0; c < 4; c++) begin
          a0 = st[4*c]; a1 = st[4*c+1]; a2 = st[4*c+2]; a3 = st[4*c+3];
          st[4*c]   = gf_mul(a0, 14) ^ gf_mul(a1, 11) ^ gf_mul(a2, 13) ^ gf_mul(a3, 9);
          st[4*c+1] = gf_mul(a0, 9) ^ gf_mul(a1, 14) ^ gf_mul(a2, 11) ^ gf_mul(a3, 13);
          st[4*c+2] = gf_mul(a0, 13) ^ gf_mul(a1, 9) ^ gf_mul(a2, 14) ^ gf_mul(a3, 11);
          st[4*c+3] = gf_mul(a0, 11) ^ gf_mul(a1, 13) ^ gf_mul(a2, 9) ^ gf_mul(a3, 14);
        end
      end
    end
    for (int i = 0; i < 16; i++) res[127-8*i -: 8] = st[i];
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("MISMATCH %s at result %0d: got %h want %h", what, n_results, got, want);
    n_errors++;
  endtask

  task automatic queue_job(op_e op, logic func, logic [127:0] data);
    job_t j;
    j.op = op; j.func = func; j.data = data;
    pending_jobs.push_back(j);
  endtask

  task automatic queue_key(logic [127:0] k);
    queue_job(OpKeyHigh, 1'b0, {64'h0, k[127:64]});
    queue_job(OpKeyLow, 1'b0, {64'h0, k[63:0]});
  endtask

  function automatic logic [63:0] rand64();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return 64'h1 << $urandom_range(0, 63);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // driver
  always @(negedge clk_i) begin
    logic       nxt_start, nxt_we, idle_roll;
    int         idle_pct;
    job_t       j;
    nxt_start = start_i;
    nxt_we = 1'b0;
    if (rst_ni && !(start_i && n_accepted != n_issued)) begin
      nxt_start = 1'b0;
      idle_pct = n_issued < 250 ? 30 : (n_issued < 500 ? 70 : 0);
      idle_roll = $urandom_range(0, 99) < idle_pct;
      if (pending_jobs.size() != 0 && !idle_roll) begin
        j = pending_jobs[0];
        case (j.op)
          OpBlock: begin
            void'(pending_jobs.pop_front());
            in_i <= '{func: j.func, block_high: j.data[127:64], block_low: j.data[63:0]};
            nxt_start = 1'b1;
            n_issued++;
          end
          OpKeyHigh, OpKeyLow: begin
            if (cipher_expect.size() == 0 && !busy_o && quiet_cycles >= 4) begin
              void'(pending_jobs.pop_front());
              nxt_we = 1'b1;
              cfg_idx_i <= (j.op == OpKeyHigh) ? aes_pkg::CfgKeyHigh : aes_pkg::CfgKeyLow;
              cfg_data_i <= j.data[63:0];
            end
          end
          default: begin
            if (cipher_expect.size() == 0) void'(pending_jobs.pop_front());
          end
        endcase
      end
    end
    start_i <= nxt_start;
    cfg_we_i <= nxt_we;
  end

  // monitor and predictor
  always @(posedge clk_i) begin
    logic [127:0] want;
    logic         act;
    if (rst_ni) begin
      act = 1'b0;
      if (cfg_we_i) begin
        if (cfg_idx_i == aes_pkg::CfgKeyHigh) key_hi_q = cfg_data_i;
        else key_lo_q = cfg_data_i;
        expand_keys();
        n_keys++;
        act = 1'b1;
      end
      if (start_i && !busy_o) begin
        cipher_expect.push_back(aes_predict(in_i.func, {in_i.block_high, in_i.block_low}));
        n_accepted++;
        act = 1'b1;
      end
      if (done_o) begin
        act = 1'b1;
        if (cipher_expect.size() == 0) begin
          report_mismatch("unexpected result_high", out_o.result_high, 64'h0);
        end else begin
          want = cipher_expect.pop_front();
          if (out_o.result_high !== want[127:64])
            report_mismatch("result_high", out_o.result_high, want[127:64]);
          if (out_o.result_low !== want[63:0])
            report_mismatch("result_low", out_o.result_low, want[63:0]);
        end
        n_results++;
      end
      quiet_cycles <= act ? 0 : quiet_cycles + 1;
      if (quiet_cycles > 3000) begin
        $display("Timeout with %0d results outstanding", cipher_expect.size());
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    logic [127:0] k;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    queue_key(128'h000102030405060708090a0b0c0d0e0f);
    queue_job(OpBlock, 1'b1, 128'h00112233445566778899aabbccddeeff);
    queue_job(OpBlock, 1'b0, 128'h69c4e0d86a7b0430d8cdb78070b4c55a);
    queue_job(OpBlock, 1'b1, '0);
    queue_job(OpBlock, 1'b0, '1);
    queue_key(128'h2b7e151628aed2a6abf7158809cf4f3c);
    queue_job(OpBlock, 1'b1, 128'h3243f6a8885a308d313198a2e0370734);
    queue_job(OpBlock, 1'b0, 128'h3925841d02dc09fbdc118597196a0b32);
    queue_key('1);
    queue_job(OpBlock, 1'b1, '1);
    queue_job(OpBlock, 1'b0, '0);
    queue_key('0);
    queue_job(OpBlock, 1'b1, '0);
    queue_job(OpBlock, 1'b0, '1);
    // one half only: expansion uses the other half as it stands
    queue_job(OpKeyLow, 1'b0, {64'h0, 64'hfedcba9876543210});
    queue_job(OpBlock, 1'b1, 128'h0123456789abcdeffedcba9876543210);
    queue_job(OpKeyHigh, 1'b0, {64'h0, 64'h8000000000000001});
    queue_job(OpBlock, 1'b0, 128'h80000000000000000000000000000001);

    for (int i = 0; i < 700; i++) begin
      if (i % 60 == 59) begin
        k = {rand64(), rand64()};
        case ($urandom_range(0, 2))
          0: queue_key(k);
          1: queue_job(OpKeyHigh, 1'b0, {64'h0, k[127:64]});
          default: queue_job(OpKeyLow, 1'b0, {64'h0, k[63:0]});
        endcase
      end
      if (i % 97 == 50) queue_job(OpDrain, 1'b0, '0);
      queue_job(OpBlock, 1'($urandom_range(0, 1)), {rand64(), rand64()});
    end

    wait (pending_jobs.size() == 0 && n_accepted == n_issued);
    wait (cipher_expect.size() == 0);
    repeat (20) @(posedge clk_i);
    $display("Ran %0d blocks (encrypt and decrypt) over %0d key writes, %0d results checked.",
             n_accepted, n_keys, n_results);
    if (n_errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("Verification failed");
    end
    $finish;
  end
endmodule
